// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package stbs_pkg;

    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         write_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
        logic [IDX_W-1:0]         range_left;
        logic [IDX_W-1:0]         range_right;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic load;
        logic read;
        logic go_right;
        logic go_left;
        logic report_hit;
        logic report_miss;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic hit;
        logic less;
    } dp_status_t;

endpackage

// ===== rtl/stbs_ctrl.sv =====
// Controller state machine for the binary search: sequences probes and results.
// Depends on stbs_pkg; drives stbs_datapath through dp_cmd_t.
module stbs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   op,
    input  stbs_pkg::dp_status_t   status,
    output stbs_pkg::dp_cmd_t      cmd,
    output logic                   busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == stbs_pkg::OP_SEARCH)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_PROBE:
            begin
                if (status.empty)
                begin
                    cmd.report_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.hit)
                begin
                    cmd.report_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.less)
                begin
                    cmd.go_right = 1'b1;
                    state_next   = ST_PROBE;
                end
                else
                begin
                    cmd.go_left = 1'b1;
                    state_next  = ST_PROBE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/stbs_datapath.sv =====
// Datapath for the binary search: table memory, bounds, midpoint and compare.
// Depends on stbs_pkg; commanded by stbs_ctrl.
module stbs_datapath
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  stbs_pkg::item_t        item,
    input  stbs_pkg::dp_cmd_t      cmd,
    output stbs_pkg::dp_status_t   status,
    output stbs_pkg::result_t      result,
    output logic                   done
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W  = stbs_pkg::IDX_W + 2;
    localparam int unsigned MAX_IDX = TABLE_DEPTH - 1;

    logic signed [stbs_pkg::DATA_W-1:0] table_mem [0:TABLE_DEPTH-1];

    logic signed [POS_W-1:0]            lo_reg, lo_next;
    logic signed [POS_W-1:0]            hi_reg, hi_next;
    logic signed [stbs_pkg::DATA_W-1:0] key_reg, key_next;
    logic [stbs_pkg::IDX_W-1:0]         mid_reg, mid_next;
    logic signed [stbs_pkg::DATA_W-1:0] rd_data_reg;
    logic                               found_reg, found_next;
    logic [stbs_pkg::IDX_W-1:0]         found_index_reg, found_index_next;
    logic                               done_reg, done_next;

    logic signed [POS_W-1:0]            hi_init;
    logic signed [POS_W-1:0]            span;
    logic signed [POS_W-1:0]            mid_wide;
    logic [stbs_pkg::IDX_W-1:0]         mid_w;
    logic                               write_ok;

    assign write_ok = (32'(item.write_index) < 32'(TABLE_DEPTH));

    // clip the top of the range to the table
    always_comb
    begin
        if (32'(item.range_right) > MAX_IDX)
        begin
            hi_init = POS_W'(MAX_IDX);
        end
        else
        begin
            hi_init = {2'b00, item.range_right};
        end
    end

    // span is non-negative whenever the midpoint is used
    assign span     = hi_reg - lo_reg;
    assign mid_wide = lo_reg + (span >>> 1);
    assign mid_w    = mid_wide[stbs_pkg::IDX_W-1:0];

    assign status.empty = (lo_reg > hi_reg);
    assign status.hit   = ($signed(rd_data_reg) == $signed(key_reg));
    assign status.less  = ($signed(rd_data_reg) < $signed(key_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.write && write_ok)
        begin
            table_mem[ADDR_W'(item.write_index)] <= item.entry_value;
        end
        if (cmd.read)
        begin
            rd_data_reg <= table_mem[ADDR_W'(mid_w)];
        end
    end

    always_comb
    begin
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        key_next         = key_reg;
        mid_next         = mid_reg;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        done_next        = 1'b0;
        if (cmd.load)
        begin
            lo_next  = {2'b00, item.range_left};
            hi_next  = hi_init;
            key_next = item.search_key;
        end
        if (cmd.read)
        begin
            mid_next = mid_w;
        end
        if (cmd.go_right)
        begin
            lo_next = {2'b00, mid_reg} + POS_W'(1);
        end
        if (cmd.go_left)
        begin
            hi_next = {2'b00, mid_reg} - POS_W'(1);
        end
        if (cmd.report_hit)
        begin
            found_next       = 1'b1;
            found_index_next = mid_reg;
            done_next        = 1'b1;
        end
        if (cmd.report_miss)
        begin
            found_next       = 1'b0;
            found_index_next = '0;
            done_next        = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        key_reg         <= key_next;
        mid_reg         <= mid_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign result.found       = found_reg;
    assign result.found_index = found_index_reg;
    assign done               = done_reg;

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Channel   Handshake              Payload
// item      start / busy           stbs_pkg::item_t (write or search)
// result    done (one-cycle pulse) stbs_pkg::result_t (found, found_index)
//
// A write transfer completes at its accepting edge; busy stays low.
// A search makes probes of a memory read, then a compare, plus a final bounds
// check on a miss; busy stays high throughout. The result pulses on done in the
// first cycle that busy is low; the next start may be taken in that same cycle.
// Reset clears control only; the table is undefined until written.
module sorted_table_binary_search
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  stbs_pkg::item_t     item,
    output logic                done,
    output stbs_pkg::result_t   result
);

    stbs_pkg::dp_cmd_t    cmd;
    stbs_pkg::dp_status_t status;

    stbs_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (item.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    stbs_datapath
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .done   (done)
    );

endmodule

// ===== rtl/stbs_checker.sv =====
// Port-level checks for sorted_table_binary_search, bound to the top level.
// Depends on stbs_pkg and the top level's ports.
module stbs_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input stbs_pkg::item_t     item,
    input logic                done,
    input stbs_pkg::result_t   result
);

    // a result only follows a search in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result without a preceding search");

    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == stbs_pkg::OP_WRITE)) |=> (!busy && !done))
        else $error("write transfer raised busy or a result");

    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.op == stbs_pkg::OP_SEARCH)) |=> busy)
        else $error("search transfer did not raise busy");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.found_index == '0))
        else $error("miss with nonzero index");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

// ===== dv/sorted_table_binary_search_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_binary_search: table writes and range searches.
// Depends on rtl/stbs_pkg.sv and rtl/sorted_table_binary_search.sv.
module sorted_table_binary_search_test;

    localparam int DEPTH      = 256;
    localparam int RANDOM_OPS = 900;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN      = 25;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    stbs_pkg::item_t   item = '0;
    stbs_pkg::result_t result;

    sorted_table_binary_search #(.TABLE_DEPTH(DEPTH)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // stimulus side: what the table holds once every queued item has been applied
    logic signed [31:0] planned_vals[DEPTH];
    bit                 planned_written[DEPTH];
    bit                 stray_probe;

    // prediction side: table contents as of the last accepted transfer
    logic signed [31:0] table_vals[DEPTH];

    stbs_pkg::item_t   pending_items[$];
    stbs_pkg::result_t expected_results[$];

    int  err_count = 0;
    int  writes_seen = 0;
    int  searches_seen = 0;
    int  hits_seen = 0;
    int  misses_seen = 0;
    int  cycle_count = 0;
    bit  xfer = 1'b0;
    int  gap_after = 0;
    int  idle_left = 0;
    int  burst_left = 0;

    // Binary search over the planned table (when on_plan) or the predicted one.
    function automatic stbs_pkg::result_t table_walk(input bit on_plan,
                                                     input logic signed [31:0] key,
                                                     input int lo, input int hi);
        stbs_pkg::result_t r;
        int mid;
        logic signed [31:0] probe;
        r = '0;
        if (hi > DEPTH - 1)
            hi = DEPTH - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (on_plan && !planned_written[mid])
                stray_probe = 1'b1;
            probe = on_plan ? planned_vals[mid] : table_vals[mid];
            if (probe == key)
            begin
                r.found = 1'b1;
                r.found_index = mid[7:0];
                lo = hi + 1;
            end
            else if (probe < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return r;
    endfunction

    task automatic push_write(input int idx, input logic signed [31:0] val);
        stbs_pkg::item_t it;
        it.op          = stbs_pkg::OP_WRITE;
        it.write_index = idx[7:0];
        it.entry_value = val;
        it.search_key  = $urandom;
        it.range_left  = 8'($urandom);
        it.range_right = 8'($urandom);
        pending_items.push_back(it);
        planned_vals[idx]    = val;
        planned_written[idx] = 1'b1;
    endtask

    // Queue a search only if every probe it makes lands on a written entry.
    task automatic offer_search(input logic signed [31:0] key, input int lo, input int hi,
                                output bit ok);
        stbs_pkg::item_t   it;
        stbs_pkg::result_t unused;
        stray_probe = 1'b0;
        unused = table_walk(1'b1, key, lo, hi);
        ok = !stray_probe;
        if (ok)
        begin
            it.op          = stbs_pkg::OP_SEARCH;
            it.write_index = 8'($urandom);
            it.entry_value = $urandom;
            it.search_key  = key;
            it.range_left  = lo[7:0];
            it.range_right = hi[7:0];
            pending_items.push_back(it);
        end
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic launch_next();
        int roll;
        item  <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left > 0)
        begin
            burst_left--;
            gap_after = 0;
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                burst_left = $urandom_range(20, 60);
                gap_after = 0;
            end
            else if (roll < 11)
                gap_after = $urandom_range(15, 40);
            else
                gap_after = $urandom_range(0, 3);
        end
    endtask

    // Driver: hold start until the transfer, then go on or idle for the chosen gap.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && xfer)
        begin
            if (gap_after == 0 && pending_items.size() > 0)
                launch_next();
            else
            begin
                start <= 1'b0;
                idle_left = gap_after;
            end
        end
        else if (!start)
        begin
            if (idle_left > 0)
                idle_left--;
            else if (pending_items.size() > 0)
                launch_next();
        end
    end

    // Monitor: check results first, then predict for a transfer taken at this edge.
    always @(posedge clk)
    begin : watch
        stbs_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    flag_error($sformatf("result found=%0b index=%0d with none pending",
                                         result.found, result.found_index));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.found !== want.found || result.found_index !== want.found_index)
                        flag_error($sformatf("found exp %0b got %0b, index exp %0d got %0d",
                                             want.found, result.found,
                                             want.found_index, result.found_index));
                    if (want.found)
                        hits_seen++;
                    else
                        misses_seen++;
                end
            end
            xfer = start && !busy;
            if (xfer)
            begin
                if (item.op == stbs_pkg::OP_WRITE)
                begin
                    writes_seen++;
                    if (item.write_index < DEPTH)
                        table_vals[item.write_index] = item.entry_value;
                end
                else
                begin
                    searches_seen++;
                    expected_results.push_back(table_walk(1'b0, item.search_key,
                                                          int'(item.range_left),
                                                          int'(item.range_right)));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles, %0d items still queued",
                     cycle_count, pending_items.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic signed [31:0] run_vals[DEPTH];
        logic signed [31:0] key;
        longint cur;
        longint step_max;
        int n_directed;
        int roll;
        int run_len;
        int base;
        int searches;
        int lo;
        int hi;
        int pick;
        bit wide;
        bit ok;

        // directed: extremes, hits at both ends, misses between entries and off the left end, empty ranges
        push_write(0, -100);
        push_write(1, -1);
        push_write(2, 0);
        push_write(3, 1);
        push_write(4, KEY_MAX);
        push_write(5, KEY_MIN);
        push_write(254, 5);
        push_write(255, KEY_MAX);
        offer_search(-100, 0, 4, ok);
        offer_search(KEY_MAX, 0, 4, ok);
        offer_search(0, 0, 4, ok);
        offer_search(7, 0, 4, ok);
        offer_search(KEY_MIN, 0, 4, ok);    // walks left past index zero
        offer_search(KEY_MIN, 5, 5, ok);
        offer_search(KEY_MAX, 254, 255, ok);
        offer_search(6, 254, 255, ok);
        offer_search(0, 200, 100, ok);
        offer_search(KEY_MAX, 255, 0, ok);
        offer_search(-1, 0, 5, ok);         // range holds an out-of-order entry
        n_directed = pending_items.size();

        while (pending_items.size() < n_directed + RANDOM_OPS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                // sorted run written in place, then searched
                run_len = ($urandom_range(0, 49) == 0) ? $urandom_range(64, DEPTH)
                                                       : $urandom_range(1, 24);
                base = $urandom_range(0, DEPTH - run_len);
                wide = $urandom_range(0, 2) != 0;
                if (wide)
                begin
                    cur = ($urandom_range(0, 3) == 0) ? longint'(KEY_MIN)
                                                      : longint'($signed($urandom));
                    step_max = (longint'(KEY_MAX) - cur) / run_len;
                end
                else
                begin
                    cur = longint'($urandom_range(0, 200)) - 100;
                    step_max = 2;
                end
                for (int i = 0; i < run_len; i++)
                begin
                    run_vals[i] = cur[31:0];
                    cur += $urandom_range(0, 32'(step_max));
                end
                if (wide && $urandom_range(0, 3) == 0)
                    run_vals[run_len - 1] = KEY_MAX;
                for (int i = 0; i < run_len; i++)
                    push_write(base + i, run_vals[i]);
                searches = $urandom_range(2, 8);
                for (int s = 0; s < searches; s++)
                begin
                    pick = $urandom_range(0, run_len - 1);
                    case ($urandom_range(0, 5))
                        0, 1: key = run_vals[pick];
                        2:    key = run_vals[pick] + 1;
                        3:    key = run_vals[pick] - 1;
                        4:    key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
                        default: key = $urandom;
                    endcase
                    case ($urandom_range(0, 5))
                        0, 1:
                        begin
                            lo = base;
                            hi = base + run_len - 1;
                        end
                        2:
                        begin
                            lo = base + $urandom_range(1, run_len);
                            hi = lo - $urandom_range(1, lo);
                        end
                        default:
                        begin
                            lo = base + $urandom_range(0, run_len - 1);
                            hi = $urandom_range(lo, base + run_len - 1);
                        end
                    endcase
                    if (lo > DEPTH - 1)
                        lo = DEPTH - 1;
                    offer_search(key, lo, hi, ok);
                end
            end
            else if (roll < 70)
                push_write($urandom_range(0, DEPTH - 1), $urandom);
            else if (roll < 85)
            begin
                ok = 1'b0;
                for (int t = 0; t < 4 && !ok; t++)
                begin
                    lo = $urandom_range(0, DEPTH - 1);
                    hi = $urandom_range(lo, DEPTH - 1);
                    key = ($urandom_range(0, 1) && planned_written[hi]) ? planned_vals[hi]
                                                                        : $urandom;
                    offer_search(key, lo, hi, ok);
                end
                if (!ok)
                    offer_search($urandom, DEPTH - 1, 0, ok);
            end
            else
            begin
                lo = $urandom_range(1, DEPTH - 1);
                offer_search($urandom, lo, $urandom_range(0, lo - 1), ok);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (pending_items.size() != 0 || start || expected_results.size() != 0);
        repeat (DRAIN) @(posedge clk);

        if (expected_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("Covered %0d table writes and %0d searches (%0d hits, %0d misses)",
                 writes_seen, searches_seen, hits_seen, misses_seen);
        $display("Mismatches: %0d, cycles: %0d", err_count, cycle_count);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
